// ===== src/pstt_pkg.sv =====
// Shared character codes and byte classification helpers for the term tokenizer.
package pstt_pkg;

  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5C;

  // Offset from upper to lower case ASCII letters
  localparam logic [7:0] CaseOffset  = 8'd32;

  // Request codes on the input channel
  localparam logic ReqByte = 1'b0;
  localparam logic ReqEod  = 1'b1;

  // Term bytes: digits, ASCII letters and anything with the top bit set
  function automatic logic is_term_byte(input logic [7:0] b);
    logic res;
    res = b[7] ||
          ((b >= 8'h30) && (b <= 8'h39)) ||
          ((b >= 8'h61) && (b <= 8'h7A)) ||
          ((b >= 8'h41) && (b <= 8'h5A));
    return res;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] res;
    res = b;
    if ((b >= 8'h41) && (b <= 8'h5A)) begin
      res = b + CaseOffset;
    end
    return res;
  endfunction

endpackage

// ===== src/python_source_term_tokenizer.sv =====
// Top level of the Python source term tokenizer: scanner state and result register.
//
// Takes one source byte (or an end-of-document marker) per transaction and
// yields at most one term byte per transaction. Each accepted transaction is
// processed combinationally: the scanner state machine and the term
// logic sit between the input port and one result register, so a new
// transaction is taken every cycle as long as the result register is empty or
// is being drained in the same cycle. Bytes inside string literals and comments
// are skipped; term letters come out in lower case, and the last byte of a
// term is marked when a non-term byte closes it. An end-of-document transaction
// flushes a pending term with its dropped flag set and returns the scanner to
// its reset state; doc_id is kept. There is no setup time after reset.
module python_source_term_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  src_byte_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  term_byte_o,
  output logic        term_last_o,
  output logic        term_dropped_o,
  output logic [31:0] doc_number_o
);
  import pstt_pkg::*;

  // Scanner modes
  localparam logic [3:0] ModeNormal  = 4'd0;
  localparam logic [3:0] ModeQuoteD  = 4'd1;
  localparam logic [3:0] ModeQuoteE  = 4'd2;
  localparam logic [3:0] ModeLit1    = 4'd3;
  localparam logic [3:0] ModeLit1Esc = 4'd4;
  localparam logic [3:0] ModeLit3    = 4'd5;
  localparam logic [3:0] ModeLit3Esc = 4'd6;
  localparam logic [3:0] ModeLit3D   = 4'd7;
  localparam logic [3:0] ModeLit3E   = 4'd8;
  localparam logic [3:0] ModeComment = 4'd9;

  logic [31:0] doc_id_q;
  logic [3:0]  mode_q, mode_d;
  logic [7:0]  quote_q, quote_d;
  logic [7:0]  look_q, look_d;
  logic [7:0]  held_q, held_d;
  logic        open_q, open_d;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_drop_q;
  logic [31:0] out_doc_q;

  logic        accept;
  logic        do_term;
  logic        emit;
  logic        emit_last;
  logic        emit_drop;

  // Take a transaction unless a held result is stuck downstream
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Scanner next state; do_term marks bytes that go to term handling
  always_comb begin
    mode_d  = mode_q;
    quote_d = quote_q;
    look_d  = look_q;
    do_term = 1'b0;
    case (mode_q)
      ModeQuoteD: begin
        look_d = src_byte_i;
        mode_d = ModeQuoteE;
      end
      ModeQuoteE: begin
        if ((look_q == quote_q) && (src_byte_i == quote_q)) begin
          mode_d = ModeLit3;
        end else if (look_q == quote_q) begin
          // empty literal; the byte after it may open a comment, else goes to term handling
          if (src_byte_i == ChHash) begin
            mode_d = ModeComment;
          end else begin
            mode_d  = ModeNormal;
            do_term = 1'b1;
          end
        end else if ((src_byte_i == quote_q) && (look_q != ChBackslash)) begin
          mode_d = ModeNormal;
        end else begin
          mode_d = ModeLit1;
        end
      end
      ModeLit1: begin
        if (src_byte_i == ChBackslash) begin
          mode_d = ModeLit1Esc;
        end else if (src_byte_i == quote_q) begin
          mode_d = ModeNormal;
        end
      end
      ModeLit1Esc: begin
        mode_d = ModeLit1;
      end
      ModeLit3: begin
        if (src_byte_i == ChBackslash) begin
          mode_d = ModeLit3Esc;
        end else if (src_byte_i == quote_q) begin
          mode_d = ModeLit3D;
        end
      end
      ModeLit3Esc: begin
        mode_d = ModeLit3;
      end
      ModeLit3D: begin
        mode_d = (src_byte_i == quote_q) ? ModeLit3E : ModeLit3;
      end
      ModeLit3E: begin
        mode_d = (src_byte_i == quote_q) ? ModeNormal : ModeLit3;
      end
      ModeComment: begin
        if (src_byte_i == ChNewline) begin
          mode_d  = ModeNormal;
          do_term = 1'b1;
        end
      end
      default: begin
        // normal scanning, also taken by unused mode codes
        if ((src_byte_i == ChDquote) || (src_byte_i == ChSquote)) begin
          quote_d = src_byte_i;
          mode_d  = ModeQuoteD;
        end else if (src_byte_i == ChHash) begin
          mode_d = ModeComment;
        end else begin
          mode_d  = ModeNormal;
          do_term = 1'b1;
        end
      end
    endcase
  end

  // Term tracking and result selection, end of document overrides all
  always_comb begin
    held_d    = held_q;
    open_d    = open_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_drop = 1'b0;
    if (req_type_i == ReqEod) begin
      emit      = open_q;
      emit_drop = 1'b1;
      held_d    = 8'd0;
      open_d    = 1'b0;
    end else if (do_term) begin
      if (is_term_byte(src_byte_i)) begin
        emit   = open_q;
        held_d = to_lower(src_byte_i);
        open_d = 1'b1;
      end else if (open_q) begin
        emit      = 1'b1;
        emit_last = 1'b1;
        open_d    = 1'b0;
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doc_id_q <= 32'd0;
    end else if (cfg_we_i) begin
      doc_id_q <= cfg_wdata_i;
    end
  end

  // Scanner state, updated per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeNormal;
      quote_q <= 8'd0;
      look_q  <= 8'd0;
      held_q  <= 8'd0;
      open_q  <= 1'b0;
    end else if (accept) begin
      held_q <= held_d;
      open_q <= open_d;
      if (req_type_i == ReqEod) begin
        mode_q  <= ModeNormal;
        quote_q <= 8'd0;
        look_q  <= 8'd0;
      end else begin
        mode_q  <= mode_d;
        quote_q <= quote_d;
        look_q  <= look_d;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded only when a term byte is produced
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_byte_q <= held_q;
      out_last_q <= emit_last;
      out_drop_q <= emit_drop;
      out_doc_q  <= doc_id_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign term_byte_o    = out_byte_q;
  assign term_last_o    = out_last_q;
  assign term_dropped_o = out_drop_q;
  assign doc_number_o   = out_doc_q;

endmodule

// ===== verif/tb_python_source_term_tokenizer.sv =====
// Self-checking testbench for the Python source term tokenizer.
`timescale 1ns / 1ps

module tb_python_source_term_tokenizer;
  import pstt_pkg::*;

  // Scanner modes of the predictor
  typedef enum logic [3:0] {
    ScanCode,
    ScanQuoteD,
    ScanQuoteE,
    ScanLit1,
    ScanLit1Esc,
    ScanLit3,
    ScanLit3Esc,
    ScanLit3D,
    ScanLit3E,
    ScanComment
  } scan_mode_e;

  typedef struct packed {
    logic [7:0]  term_byte;
    logic        last;
    logic        dropped;
    logic [31:0] doc;
  } term_beat_t;

  localparam logic [7:0] ChSpace = 8'h20;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we       = 1'b0;
  logic [31:0] cfg_wdata    = '0;
  logic        in_valid     = 1'b0;
  logic        req_type     = ReqByte;
  logic [7:0]  src_byte     = '0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  term_byte;
  logic        term_last;
  logic        term_dropped;
  logic [31:0] doc_number;

  // Predictor state
  scan_mode_e  mode_m      = ScanCode;
  logic [7:0]  quote_m     = '0;
  logic [7:0]  look_m      = '0;
  logic [7:0]  held_m      = '0;
  logic        open_m      = 1'b0;
  logic [31:0] doc_model   = '0;

  term_beat_t  expected_terms[$];
  int          mismatch_cnt = 0;
  int          items_sent   = 0;
  int          burst_left   = 0;

  python_source_term_tokenizer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .src_byte_i     (src_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .term_byte_o    (term_byte),
    .term_last_o    (term_last),
    .term_dropped_o (term_dropped),
    .doc_number_o   (doc_number)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Term predictor
  // ---------------------------------------------------------------------------
  function automatic logic is_word_char(input logic [7:0] b);
    return b[7] || (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A]}) ? (b | 8'h20) : b;
  endfunction

  task automatic push_term(input logic [7:0] b, input logic last, input logic dropped);
    term_beat_t t;
    t.term_byte = b;
    t.last      = last;
    t.dropped   = dropped;
    t.doc       = doc_model;
    expected_terms.push_back(t);
  endtask

  // Word building: a non-word byte closes the pending term
  task automatic feed_term(input logic [7:0] b);
    if (is_word_char(b)) begin
      if (open_m) push_term(held_m, 1'b0, 1'b0);
      held_m = fold_case(b);
      open_m = 1'b1;
    end else if (open_m) begin
      push_term(held_m, 1'b1, 1'b0);
      open_m = 1'b0;
    end
  endtask

  task automatic feed_code(input logic [7:0] b);
    if (b == ChHash) mode_m = ScanComment;
    else feed_term(b);
  endtask

  task automatic predict_terms(input logic req, input logic [7:0] b);
    if (req == ReqEod) begin
      if (open_m) push_term(held_m, 1'b0, 1'b1);
      mode_m  = ScanCode;
      quote_m = '0;
      look_m  = '0;
      held_m  = '0;
      open_m  = 1'b0;
    end else begin
      case (mode_m)
        ScanQuoteD: begin
          look_m = b;
          mode_m = ScanQuoteE;
        end
        ScanQuoteE: begin
          if (look_m == quote_m && b == quote_m) begin
            mode_m = ScanLit3;
          end else if (look_m == quote_m) begin
            // empty literal, the byte after it may open a comment, else goes to term building
            mode_m = ScanCode;
            feed_code(b);
          end else if (b == quote_m && look_m != ChBackslash) begin
            mode_m = ScanCode;
          end else begin
            mode_m = ScanLit1;
          end
        end
        ScanLit1: begin
          if (b == ChBackslash) mode_m = ScanLit1Esc;
          else if (b == quote_m) mode_m = ScanCode;
        end
        ScanLit1Esc: mode_m = ScanLit1;
        ScanLit3: begin
          if (b == ChBackslash) mode_m = ScanLit3Esc;
          else if (b == quote_m) mode_m = ScanLit3D;
        end
        ScanLit3Esc: mode_m = ScanLit3;
        // lookahead bytes that miss are dropped unexamined
        ScanLit3D: mode_m = (b == quote_m) ? ScanLit3E : ScanLit3;
        ScanLit3E: mode_m = (b == quote_m) ? ScanCode : ScanLit3;
        ScanComment: begin
          if (b == ChNewline) begin
            mode_m = ScanCode;
            feed_term(b);
          end
        end
        default: begin
          if (b == ChDquote || b == ChSquote) begin
            quote_m = b;
            mode_m  = ScanQuoteD;
          end else begin
            mode_m = ScanCode;
            feed_code(b);
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : check_terms
    term_beat_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_terms.size() == 0) begin
        flag_mismatch($sformatf("unexpected term byte %02h last %0b dropped %0b doc %08h",
                                term_byte, term_last, term_dropped, doc_number));
      end else begin
        want = expected_terms.pop_front();
        if (term_byte !== want.term_byte || term_last !== want.last ||
            term_dropped !== want.dropped || doc_number !== want.doc) begin
          flag_mismatch($sformatf(
            "term byte exp %02h/%0b/%0b/%08h got %02h/%0b/%0b/%08h (byte/last/drop/doc)",
            want.term_byte, want.last, want.dropped, want.doc,
            term_byte, term_last, term_dropped, doc_number));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output back-pressure: four stall styles, each picked at random
  // ---------------------------------------------------------------------------
  int stall_style = 0;
  int stall_span  = 0;
  int stall_run   = 0;

  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_span  = $urandom_range(20, 120);
    end
    stall_span--;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ($urandom_range(0, 4) != 0);
      default: begin
        if (stall_run == 0) begin
          out_stall <= ~out_stall;
          stall_run = $urandom_range(1, 10);
        end else begin
          stall_run--;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // One transaction, with bursty idle gaps in front of it
  task automatic send_item(input logic req, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= req;
    src_byte <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_terms(req, b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(ReqByte, s[i]);
  endtask

  // Hold off input until every expected term byte is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_doc_id(input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    doc_model = v;
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 8))
      0, 1, 2: return 8'($urandom_range(8'h61, 8'h7A));
      3, 4:    return 8'($urandom_range(8'h41, 8'h5A));
      5, 6:    return 8'($urandom_range(8'h30, 8'h39));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic logic [7:0] gap_char();
    string seps;
    seps = " \t\n()[]{}=,.:;_+-*/<>@!";
    return seps[$urandom_range(0, seps.len() - 1)];
  endfunction

  function automatic logic [7:0] literal_char(input logic [7:0] q);
    case ($urandom_range(0, 15))
      0:       return ChBackslash;
      1:       return q;
      2:       return (q == ChDquote) ? ChSquote : ChDquote;
      3:       return ChNewline;
      4:       return 8'($urandom_range(0, 255));
      5:       return ChSpace;
      default: return word_char();
    endcase
  endfunction

  // One piece of source text: mostly well formed, some noise
  task automatic send_piece();
    int         kind;
    int         len;
    logic [7:0] q;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(0, 8);
    q    = $urandom_range(0, 1) ? ChDquote : ChSquote;
    if (kind < 34) begin
      repeat (len + 1) send_item(ReqByte, word_char());
    end else if (kind < 58) begin
      send_item(ReqByte, gap_char());
    end else if (kind < 70) begin
      send_item(ReqByte, q);
      repeat (len) send_item(ReqByte, literal_char(q));
      send_item(ReqByte, q);
    end else if (kind < 78) begin
      repeat (3) send_item(ReqByte, q);
      repeat (len) send_item(ReqByte, literal_char(q));
      repeat (3) send_item(ReqByte, q);
    end else if (kind < 86) begin
      send_item(ReqByte, ChHash);
      for (int i = 0; i < len; i++) begin
        b = literal_char(q);
        if (b == ChNewline) b = ChSpace;
        send_item(ReqByte, b);
      end
      send_item(ReqByte, ChNewline);
    end else if (kind < 96) begin
      send_item(ReqByte, 8'($urandom_range(0, 255)));
    end else if (kind < 98) begin
      send_item(ReqEod, 8'($urandom_range(0, 255)));
    end else begin
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Byte values 0x00 and 0xFF, case folding, end of document with no term
  task automatic test_field_extremes();
    send_item(ReqByte, 8'h5A);
    send_item(ReqByte, 8'hFF);
    send_item(ReqByte, 8'h30);
    send_item(ReqByte, 8'h00);
    send_item(ReqEod, 8'hFF);
  endtask

  // Empty literal with a quote after it, escaped quote, short literal
  task automatic test_quote_openings();
    wait_drained();
    write_doc_id(32'hFFFF_FFFF);
    send_text("''\"");
    send_text("\"\\\"\"");
    send_text("'a'");
  endtask

  // Triple literal where a quote swallows a backslash as lost lookahead
  task automatic test_triple_literal();
    send_text("'''");
    send_text("'\\");
    send_text("'''");
  endtask

  // Empty literal followed by a comment; the newline closes the term
  task automatic test_comments();
    send_text("x\"\"#\n");
  endtask

  // A pending term is flushed as dropped
  task automatic test_end_of_document();
    send_item(ReqByte, 8'h51);
    send_item(ReqEod, 8'h00);
  endtask

  task automatic test_random_traffic();
    logic [31:0] doc_settings [5];
    int          target;
    doc_settings = '{32'h0000_0000, $urandom(), 32'hFFFF_FFFF, $urandom(), 32'h0000_0001};
    target = items_sent + 1920;
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_doc_id(doc_settings[p]);
      while (items_sent < target - (4 - p) * 384) send_piece();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_quote_openings();
    test_triple_literal();
    test_comments();
    test_end_of_document();
    test_random_traffic();
    wait_drained();
    if (mismatch_cnt == 0 && expected_terms.size() == 0) begin
      $display("python_source_term_tokenizer: match");
    end else begin
      $display("python_source_term_tokenizer: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("python_source_term_tokenizer: mismatch");
    $finish;
  end

endmodule
